>>> hw/rtl/slu_pkg.sv
// Package for the small LU linear solver: sizes, codes, FSM states and the
// command/status structs between controller and datapath. No dependencies.
package slu_pkg;

  localparam int MaxOrder = 3;
  localparam int DataW    = 32;
  localparam int IdxW     = 2;
  localparam int RhsBase  = MaxOrder * MaxOrder;
  localparam int MemDepth = RhsBase + MaxOrder;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int ProdW    = 2 * DataW + 2;

  typedef logic [MemAw-1:0] addr_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_SOLVE  = 2'd2
  } op_e;

  // write data select for the working store
  typedef enum logic [2:0] {
    WS_LRD,
    WS_S,
    WS_RD,
    WS_X,
    WS_PIV,
    WS_QUO
  } wsel_e;

  typedef enum logic [1:0] {
    MUL_XR,
    MUL_PV1,
    MUL_PV2
  } mulsel_e;

  typedef enum logic [1:0] {
    MODE_LU,
    MODE_FWD,
    MODE_BACK
  } mode_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_COPY, ST_SCAN_RD, ST_SCAN_ACC, ST_SCAN_ROW,
    ST_LD_S, ST_LD_S_W, ST_MA, ST_MA_W, ST_MB_W, ST_MQ, ST_MSUB,
    ST_WR_S, ST_PV1, ST_PV2, ST_PV3, ST_NEXT_I,
    ST_SWAP, ST_SW_R1, ST_SW_R2, ST_SW_W1, ST_SW_W2,
    ST_DG, ST_DG_W, ST_DV_RD, ST_DV_W, ST_DIV_RUN, ST_DIV_WR,
    ST_F0, ST_F1, ST_F2, ST_F_WR,
    ST_B0, ST_B1, ST_B_DIV, ST_B_DW,
    ST_O_RD, ST_O_W, ST_O_WAIT, ST_SING
  } state_e;

  typedef struct packed {
    logic    l_we;
    addr_t   l_waddr;
    addr_t   l_raddr;
    logic    w_we;
    addr_t   w_waddr;
    addr_t   w_raddr;
    wsel_e   w_sel;
    logic    s_ld;
    logic    s_sub;
    logic    x_ld;
    logic    prod_en;
    mulsel_e mul_sel;
    logic    q_en;
    logic    cmp_en;
    logic    best_ld;
    logic    big_clr;
    logic    big_acc;
    idx_t    scale_idx;
    idx_t    scale_idx2;
    logic    scale_we;
    logic    scale_swap;
    logic    piv_ld;
    logic    div_start;
    logic    div_back;
    logic    out_ld_sol;
    logic    out_ld_sing;
    idx_t    out_index;
    logic    out_last;
    logic    out_odd;
  } cmd_t;

  typedef struct packed {
    logic big_zero;
    logic ge;
    logic div_busy;
    logic out_busy;
  } status_t;

  function automatic addr_t mat_addr(idx_t r, idx_t c);
    mat_addr = addr_t'(r) * addr_t'(MaxOrder) + addr_t'(c);
  endfunction

  function automatic addr_t rhs_addr(idx_t r);
    rhs_addr = addr_t'(RhsBase) + addr_t'(r);
  endfunction

endpackage

>>> hw/rtl/slu_ram.sv
// Generic single write / single read RAM with registered read data.
// No dependencies.
module slu_ram #(
  parameter int Width = 32,
  parameter int Depth = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/slu_div.sv
// Bit-serial signed Q16.16 divider: (num << 16) / den, truncated, saturated.
// Depends on slu_pkg.
module slu_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [slu_pkg::DataW-1:0] num_i,
  input  logic signed [slu_pkg::DataW-1:0] den_i,
  output logic                             busy_o,
  output logic signed [slu_pkg::DataW-1:0] quo_o
);

  localparam int W    = slu_pkg::DataW;
  localparam int QuoW = W + 16;
  localparam int CntW = $clog2(QuoW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic [W-1:0]    den_q, den_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [QuoW-1:0] dvd_q, dvd_d;
  logic [W:0]      rem_sh;
  logic            take;
  logic [W-1:0]    num_mag, den_mag;

  assign num_mag = num_i[W-1] ? W'(-num_i) : W'(num_i);
  assign den_mag = den_i[W-1] ? W'(-den_i) : W'(den_i);
  assign rem_sh  = {rem_q, dvd_q[QuoW-1]};
  assign take    = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(QuoW);
      neg_d  = num_i[W-1] ^ den_i[W-1];
      den_d  = (den_mag == '0) ? W'(1) : den_mag;
      rem_d  = '0;
      dvd_d  = {num_mag, 16'b0};
    end else if (busy_q) begin
      rem_d  = take ? W'(rem_sh - {1'b0, den_q}) : W'(rem_sh);
      dvd_d  = {dvd_q[QuoW-2:0], take};
      cnt_d  = cnt_q - CntW'(1);
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  // saturate the magnitude quotient to the signed range
  always_comb begin
    if (!neg_q) begin
      quo_o = (dvd_q[QuoW-1:W-1] != '0) ? {1'b0, {(W-1){1'b1}}} : W'(dvd_q);
    end else if (dvd_q > QuoW'({1'b1, {(W-1){1'b0}}})) begin
      quo_o = {1'b1, {(W-1){1'b0}}};
    end else begin
      quo_o = W'(-dvd_q[W-1:0]);
    end
  end

  assign busy_o = busy_q;

endmodule

>>> hw/rtl/slu_dp.sv
// Datapath: load and working stores, multiplier, saturating subtract, row
// scales, pivot compare, divider and output register. Depends on slu_pkg,
// slu_ram, slu_div.
module slu_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  slu_pkg::cmd_t                    cmd_i,
  input  logic signed [slu_pkg::DataW-1:0] value_i,
  output slu_pkg::status_t                 status_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [slu_pkg::IdxW-1:0]         element_index_o,
  output logic signed [slu_pkg::DataW-1:0] solution_o,
  output logic                             singular_o,
  output logic                             odd_swaps_o,
  output logic                             last_o
);

  localparam int W  = slu_pkg::DataW;
  localparam int PW = slu_pkg::ProdW;

  logic signed [W-1:0]  l_rd, w_rd, w_wd, quo, piv_next;
  logic signed [W-1:0]  s_q, x_q, q_q, piv_q, sol_q;
  logic [W-1:0]         big_q, best_mag_q, best_scale_q, s_mag, rd_mag, scale_rd;
  logic [W-1:0]         scale_q [slu_pkg::MaxOrder];
  logic signed [PW-1:0] prod_q, cmp_q, adj;
  logic signed [W:0]    op_a, op_b;
  logic signed [PW-17:0] shr;
  logic signed [W-1:0]  q_sat, s_dif_sat;
  logic signed [W:0]    s_dif;
  logic                 div_busy;
  logic                 out_valid_q;
  logic [slu_pkg::IdxW-1:0] idx_q;
  logic                 sing_q, odd_q, last_q;

  slu_ram #(.Width(W), .Depth(slu_pkg::MemDepth)) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.l_we),
    .waddr_i (cmd_i.l_waddr),
    .wdata_i (value_i),
    .raddr_i (cmd_i.l_raddr),
    .rdata_o (l_rd)
  );

  slu_ram #(.Width(W), .Depth(slu_pkg::MemDepth)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.w_we),
    .waddr_i (cmd_i.w_waddr),
    .wdata_i (w_wd),
    .raddr_i (cmd_i.w_raddr),
    .rdata_o (w_rd)
  );

  slu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (cmd_i.div_back ? s_q : w_rd),
    .den_i   (cmd_i.div_back ? w_rd : piv_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign piv_next = (w_rd == '0) ? W'(1) : w_rd;
  assign s_mag    = s_q[W-1] ? W'(-s_q) : W'(s_q);
  assign rd_mag   = w_rd[W-1] ? W'(-w_rd) : W'(w_rd);
  assign scale_rd = scale_q[cmd_i.scale_idx];

  always_comb begin
    unique case (cmd_i.w_sel)
      slu_pkg::WS_LRD: w_wd = l_rd;
      slu_pkg::WS_S:   w_wd = s_q;
      slu_pkg::WS_RD:  w_wd = w_rd;
      slu_pkg::WS_X:   w_wd = x_q;
      slu_pkg::WS_PIV: w_wd = piv_next;
      slu_pkg::WS_QUO: w_wd = quo;
      default:         w_wd = s_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      slu_pkg::MUL_PV1: begin
        op_a = $signed({1'b0, s_mag});
        op_b = $signed({1'b0, best_scale_q});
      end
      slu_pkg::MUL_PV2: begin
        op_a = $signed({1'b0, best_mag_q});
        op_b = $signed({1'b0, scale_rd});
      end
      default: begin
        op_a = {x_q[W-1], x_q};
        op_b = {w_rd[W-1], w_rd};
      end
    endcase
  end

  // product / 2^16 truncated toward zero, then saturated
  assign adj = prod_q + (prod_q[PW-1] ? PW'(65535) : PW'(0));
  assign shr = adj[PW-1:16];
  always_comb begin
    if (shr > $signed((PW-16)'({1'b0, {(W-1){1'b1}}}))) begin
      q_sat = {1'b0, {(W-1){1'b1}}};
    end else if (shr < -$signed((PW-16)'({1'b1, {(W-1){1'b0}}}))) begin
      q_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      q_sat = W'(shr);
    end
  end

  assign s_dif = {s_q[W-1], s_q} - {q_q[W-1], q_q};
  assign s_dif_sat = (s_dif[W] != s_dif[W-1]) ?
                     (s_dif[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) :
                     W'(s_dif);

  always_ff @(posedge clk_i) begin
    if (cmd_i.s_ld) begin
      s_q <= w_rd;
    end else if (cmd_i.s_sub) begin
      s_q <= s_dif_sat;
    end
    if (cmd_i.x_ld) x_q <= w_rd;
    if (cmd_i.prod_en) prod_q <= op_a * op_b;
    if (cmd_i.cmp_en) cmp_q <= prod_q;
    if (cmd_i.q_en) q_q <= q_sat;
    if (cmd_i.piv_ld) piv_q <= piv_next;
    if (cmd_i.big_clr) begin
      big_q <= '0;
    end else if (cmd_i.big_acc && rd_mag > big_q) begin
      big_q <= rd_mag;
    end
    if (cmd_i.best_ld) begin
      best_mag_q   <= s_mag;
      best_scale_q <= scale_rd;
    end
    if (cmd_i.out_ld_sol) begin
      idx_q  <= cmd_i.out_index;
      sol_q  <= w_rd;
      sing_q <= 1'b0;
      odd_q  <= cmd_i.out_odd;
      last_q <= cmd_i.out_last;
    end else if (cmd_i.out_ld_sing) begin
      idx_q  <= '0;
      sol_q  <= '0;
      sing_q <= 1'b1;
      odd_q  <= 1'b0;
      last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < slu_pkg::MaxOrder; r++) begin
        scale_q[r] <= '0;
      end
    end else if (cmd_i.scale_we) begin
      scale_q[cmd_i.scale_idx] <= big_q;
    end else if (cmd_i.scale_swap) begin
      scale_q[cmd_i.scale_idx2] <= scale_rd;
      scale_q[cmd_i.scale_idx]  <= best_scale_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld_sol || cmd_i.out_ld_sing) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.big_zero = (big_q == '0);
  assign status_o.ge       = (cmp_q >= prod_q);
  assign status_o.div_busy = div_busy;
  assign status_o.out_busy = out_valid_q;

  assign out_valid_o     = out_valid_q;
  assign element_index_o = idx_q;
  assign solution_o      = sol_q;
  assign singular_o      = sing_q;
  assign odd_swaps_o     = odd_q;
  assign last_o          = last_q;

endmodule

>>> hw/rtl/slu_ctrl.sv
// Controller: sequencer for load, copy, row scan, Crout LU with pivoting,
// substitution and result output. Depends on slu_pkg.
module slu_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     matrix_size_we_i,
  input  logic [1:0]               matrix_size_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               operation_i,
  input  logic [slu_pkg::IdxW-1:0] row_i,
  input  logic [slu_pkg::IdxW-1:0] column_i,
  input  slu_pkg::status_t         status_i,
  output slu_pkg::cmd_t            cmd_o
);

  localparam int CopyW = $clog2(slu_pkg::MemDepth + 1);

  typedef logic [slu_pkg::IdxW-1:0] idx_t;

  slu_pkg::state_e state_q, state_d;
  slu_pkg::mode_e  mode_q, mode_d;
  idx_t            i_q, i_d, j_q, j_d, k_q, k_d, kend_q, kend_d, best_q, best_d;
  idx_t            perm_q [slu_pkg::MaxOrder];
  logic            perm_we;
  logic            parity_q, parity_d;
  logic [1:0]      size_q;
  logic [CopyW-1:0] c_q, c_d;
  idx_t            n, nm1, i_p1, k_p1, kmin, p;
  logic            in_xfer, solve_go;

  assign n        = (size_q == 2'd0) ? idx_t'(1) : idx_t'(size_q);
  assign nm1      = n - idx_t'(1);
  assign i_p1     = i_q + idx_t'(1);
  assign k_p1     = k_q + idx_t'(1);
  assign kmin     = (i_q < j_q) ? i_q : j_q;
  assign p        = perm_q[i_q];
  assign in_ready_o = (state_q == slu_pkg::ST_IDLE);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign solve_go = in_xfer && (operation_i == slu_pkg::OP_SOLVE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slu_pkg::ST_IDLE:     if (solve_go) state_d = slu_pkg::ST_COPY;
      slu_pkg::ST_COPY:     if (c_q == CopyW'(slu_pkg::MemDepth)) state_d = slu_pkg::ST_SCAN_RD;
      slu_pkg::ST_SCAN_RD:  state_d = slu_pkg::ST_SCAN_ACC;
      slu_pkg::ST_SCAN_ACC: state_d = (k_q == nm1) ? slu_pkg::ST_SCAN_ROW : slu_pkg::ST_SCAN_RD;
      slu_pkg::ST_SCAN_ROW: begin
        if (status_i.big_zero) state_d = slu_pkg::ST_SING;
        else if (i_q == nm1)   state_d = slu_pkg::ST_LD_S;
        else                   state_d = slu_pkg::ST_SCAN_RD;
      end
      slu_pkg::ST_LD_S:     state_d = slu_pkg::ST_LD_S_W;
      slu_pkg::ST_LD_S_W:   state_d = (kmin == '0) ? slu_pkg::ST_WR_S : slu_pkg::ST_MA;
      slu_pkg::ST_MA:       state_d = slu_pkg::ST_MA_W;
      slu_pkg::ST_MA_W:     state_d = slu_pkg::ST_MB_W;
      slu_pkg::ST_MB_W:     state_d = slu_pkg::ST_MQ;
      slu_pkg::ST_MQ:       state_d = slu_pkg::ST_MSUB;
      slu_pkg::ST_MSUB: begin
        if (k_p1 != kend_q) begin
          state_d = slu_pkg::ST_MA;
        end else begin
          unique case (mode_q)
            slu_pkg::MODE_LU:  state_d = slu_pkg::ST_WR_S;
            slu_pkg::MODE_FWD: state_d = slu_pkg::ST_F_WR;
            default:           state_d = slu_pkg::ST_B_DIV;
          endcase
        end
      end
      slu_pkg::ST_WR_S: begin
        priority if (i_q < j_q) state_d = slu_pkg::ST_LD_S;
        else if (i_q == j_q)    state_d = slu_pkg::ST_NEXT_I;
        else                    state_d = slu_pkg::ST_PV1;
      end
      slu_pkg::ST_PV1:      state_d = slu_pkg::ST_PV2;
      slu_pkg::ST_PV2:      state_d = slu_pkg::ST_PV3;
      slu_pkg::ST_PV3:      state_d = slu_pkg::ST_NEXT_I;
      slu_pkg::ST_NEXT_I:   state_d = (i_q == nm1) ? slu_pkg::ST_SWAP : slu_pkg::ST_LD_S;
      slu_pkg::ST_SWAP:     state_d = (best_q != j_q) ? slu_pkg::ST_SW_R1 : slu_pkg::ST_DG;
      slu_pkg::ST_SW_R1:    state_d = slu_pkg::ST_SW_R2;
      slu_pkg::ST_SW_R2:    state_d = slu_pkg::ST_SW_W1;
      slu_pkg::ST_SW_W1:    state_d = slu_pkg::ST_SW_W2;
      slu_pkg::ST_SW_W2:    state_d = (k_q == nm1) ? slu_pkg::ST_DG : slu_pkg::ST_SW_R1;
      slu_pkg::ST_DG:       state_d = slu_pkg::ST_DG_W;
      slu_pkg::ST_DG_W:     state_d = (j_q == nm1) ? slu_pkg::ST_F0 : slu_pkg::ST_DV_RD;
      slu_pkg::ST_DV_RD:    state_d = slu_pkg::ST_DV_W;
      slu_pkg::ST_DV_W:     state_d = slu_pkg::ST_DIV_RUN;
      slu_pkg::ST_DIV_RUN:  if (!status_i.div_busy) state_d = slu_pkg::ST_DIV_WR;
      slu_pkg::ST_DIV_WR: begin
        if (mode_q == slu_pkg::MODE_LU) begin
          state_d = (i_q == nm1) ? slu_pkg::ST_LD_S : slu_pkg::ST_DV_RD;
        end else begin
          state_d = (i_q == '0) ? slu_pkg::ST_O_RD : slu_pkg::ST_B0;
        end
      end
      slu_pkg::ST_F0:       state_d = slu_pkg::ST_F1;
      slu_pkg::ST_F1:       state_d = slu_pkg::ST_F2;
      slu_pkg::ST_F2:       state_d = (i_q == '0) ? slu_pkg::ST_F_WR : slu_pkg::ST_MA;
      slu_pkg::ST_F_WR:     state_d = (i_q == nm1) ? slu_pkg::ST_B0 : slu_pkg::ST_F0;
      slu_pkg::ST_B0:       state_d = slu_pkg::ST_B1;
      slu_pkg::ST_B1:       state_d = (i_q == nm1) ? slu_pkg::ST_B_DIV : slu_pkg::ST_MA;
      slu_pkg::ST_B_DIV:    state_d = slu_pkg::ST_B_DW;
      slu_pkg::ST_B_DW:     state_d = slu_pkg::ST_DIV_RUN;
      slu_pkg::ST_O_RD:     state_d = slu_pkg::ST_O_W;
      slu_pkg::ST_O_W:      state_d = slu_pkg::ST_O_WAIT;
      slu_pkg::ST_O_WAIT: begin
        if (!status_i.out_busy) begin
          state_d = (i_q == nm1) ? slu_pkg::ST_IDLE : slu_pkg::ST_O_RD;
        end
      end
      slu_pkg::ST_SING:     state_d = slu_pkg::ST_O_WAIT;
      default:              state_d = slu_pkg::ST_IDLE;
    endcase
  end

  // commands and loop counters
  always_comb begin
    cmd_o    = '0;
    cmd_o.w_sel   = slu_pkg::WS_S;
    cmd_o.mul_sel = slu_pkg::MUL_XR;
    cmd_o.l_waddr = (operation_i == slu_pkg::OP_LOAD_B) ? slu_pkg::rhs_addr(row_i) :
                    slu_pkg::mat_addr(row_i, column_i);
    cmd_o.l_we    = in_xfer && (row_i < idx_t'(slu_pkg::MaxOrder)) &&
                    ((operation_i == slu_pkg::OP_LOAD_B) ||
                     ((operation_i == slu_pkg::OP_LOAD_A) &&
                      (column_i < idx_t'(slu_pkg::MaxOrder))));
    cmd_o.scale_idx = i_q;
    cmd_o.out_index = i_q;
    cmd_o.out_last  = (i_q == nm1);
    cmd_o.out_odd   = parity_q;
    i_d = i_q; j_d = j_q; k_d = k_q; kend_d = kend_q; best_d = best_q;
    c_d = c_q; mode_d = mode_q; parity_d = parity_q;
    perm_we = 1'b0;
    unique case (state_q)
      slu_pkg::ST_IDLE: begin
        if (solve_go) begin
          c_d = '0;
          parity_d = 1'b0;
        end
      end
      slu_pkg::ST_COPY: begin
        cmd_o.l_raddr = (c_q < CopyW'(slu_pkg::MemDepth)) ? slu_pkg::addr_t'(c_q) : '0;
        cmd_o.w_we    = (c_q != '0);
        cmd_o.w_waddr = slu_pkg::addr_t'(c_q - CopyW'(1));
        cmd_o.w_sel   = slu_pkg::WS_LRD;
        c_d = c_q + CopyW'(1);
        i_d = '0; k_d = '0;
        cmd_o.big_clr = 1'b1;
      end
      slu_pkg::ST_SCAN_RD: cmd_o.w_raddr = slu_pkg::mat_addr(i_q, k_q);
      slu_pkg::ST_SCAN_ACC: begin
        cmd_o.big_acc = 1'b1;
        k_d = k_p1;
      end
      slu_pkg::ST_SCAN_ROW: begin
        k_d = '0;
        if (status_i.big_zero) begin
          i_d = nm1;
        end else begin
          cmd_o.scale_we = 1'b1;
          cmd_o.big_clr  = 1'b1;
          if (i_q == nm1) begin
            i_d = '0; j_d = '0;
            mode_d = slu_pkg::MODE_LU;
          end else begin
            i_d = i_p1;
          end
        end
      end
      slu_pkg::ST_LD_S: cmd_o.w_raddr = slu_pkg::mat_addr(i_q, j_q);
      slu_pkg::ST_LD_S_W: begin
        cmd_o.s_ld = 1'b1;
        k_d = '0;
        kend_d = kmin;
      end
      slu_pkg::ST_MA: cmd_o.w_raddr = slu_pkg::mat_addr(i_q, k_q);
      slu_pkg::ST_MA_W: begin
        cmd_o.x_ld    = 1'b1;
        cmd_o.w_raddr = (mode_q == slu_pkg::MODE_LU) ? slu_pkg::mat_addr(k_q, j_q) :
                        slu_pkg::rhs_addr(k_q);
      end
      slu_pkg::ST_MB_W: cmd_o.prod_en = 1'b1;
      slu_pkg::ST_MQ:   cmd_o.q_en = 1'b1;
      slu_pkg::ST_MSUB: begin
        cmd_o.s_sub = 1'b1;
        k_d = k_p1;
      end
      slu_pkg::ST_WR_S: begin
        cmd_o.w_we    = 1'b1;
        cmd_o.w_waddr = slu_pkg::mat_addr(i_q, j_q);
        if (i_q < j_q) begin
          i_d = i_p1;
        end else if (i_q == j_q) begin
          cmd_o.best_ld = 1'b1;
          best_d = i_q;
        end
      end
      slu_pkg::ST_PV1: begin
        cmd_o.prod_en = 1'b1;
        cmd_o.mul_sel = slu_pkg::MUL_PV1;
      end
      slu_pkg::ST_PV2: begin
        cmd_o.cmp_en  = 1'b1;
        cmd_o.prod_en = 1'b1;
        cmd_o.mul_sel = slu_pkg::MUL_PV2;
      end
      slu_pkg::ST_PV3: begin
        // later row wins a tie
        if (status_i.ge) begin
          cmd_o.best_ld = 1'b1;
          best_d = i_q;
        end
      end
      slu_pkg::ST_NEXT_I: begin
        if (i_q == nm1) k_d = '0;
        else            i_d = i_p1;
      end
      slu_pkg::ST_SWAP: begin
        perm_we = 1'b1;
        if (best_q != j_q) begin
          cmd_o.scale_swap = 1'b1;
          cmd_o.scale_idx  = j_q;
          cmd_o.scale_idx2 = best_q;
          parity_d = ~parity_q;
        end
      end
      slu_pkg::ST_SW_R1: cmd_o.w_raddr = slu_pkg::mat_addr(best_q, k_q);
      slu_pkg::ST_SW_R2: begin
        cmd_o.x_ld    = 1'b1;
        cmd_o.w_raddr = slu_pkg::mat_addr(j_q, k_q);
      end
      slu_pkg::ST_SW_W1: begin
        cmd_o.w_we    = 1'b1;
        cmd_o.w_waddr = slu_pkg::mat_addr(best_q, k_q);
        cmd_o.w_sel   = slu_pkg::WS_RD;
      end
      slu_pkg::ST_SW_W2: begin
        cmd_o.w_we    = 1'b1;
        cmd_o.w_waddr = slu_pkg::mat_addr(j_q, k_q);
        cmd_o.w_sel   = slu_pkg::WS_X;
        k_d = k_p1;
      end
      slu_pkg::ST_DG: cmd_o.w_raddr = slu_pkg::mat_addr(j_q, j_q);
      slu_pkg::ST_DG_W: begin
        cmd_o.piv_ld  = 1'b1;
        cmd_o.w_we    = 1'b1;
        cmd_o.w_waddr = slu_pkg::mat_addr(j_q, j_q);
        cmd_o.w_sel   = slu_pkg::WS_PIV;
        if (j_q == nm1) begin
          i_d = '0;
          mode_d = slu_pkg::MODE_FWD;
        end else begin
          i_d = j_q + idx_t'(1);
        end
      end
      slu_pkg::ST_DV_RD: cmd_o.w_raddr = slu_pkg::mat_addr(i_q, j_q);
      slu_pkg::ST_DV_W:  cmd_o.div_start = 1'b1;
      slu_pkg::ST_DIV_RUN: ;
      slu_pkg::ST_DIV_WR: begin
        cmd_o.w_we  = 1'b1;
        cmd_o.w_sel = slu_pkg::WS_QUO;
        if (mode_q == slu_pkg::MODE_LU) begin
          cmd_o.w_waddr = slu_pkg::mat_addr(i_q, j_q);
          if (i_q == nm1) begin
            i_d = '0;
            j_d = j_q + idx_t'(1);
          end else begin
            i_d = i_p1;
          end
        end else begin
          cmd_o.w_waddr = slu_pkg::rhs_addr(i_q);
          // row 0 done: output starts from element 0
          if (i_q != '0) i_d = i_q - idx_t'(1);
        end
      end
      slu_pkg::ST_F0: cmd_o.w_raddr = slu_pkg::rhs_addr(p);
      slu_pkg::ST_F1: begin
        cmd_o.s_ld    = 1'b1;
        cmd_o.w_raddr = slu_pkg::rhs_addr(i_q);
      end
      slu_pkg::ST_F2: begin
        cmd_o.w_we    = 1'b1;
        cmd_o.w_waddr = slu_pkg::rhs_addr(p);
        cmd_o.w_sel   = slu_pkg::WS_RD;
        k_d = '0;
        kend_d = i_q;
      end
      slu_pkg::ST_F_WR: begin
        cmd_o.w_we    = 1'b1;
        cmd_o.w_waddr = slu_pkg::rhs_addr(i_q);
        if (i_q == nm1) mode_d = slu_pkg::MODE_BACK;
        else            i_d = i_p1;
      end
      slu_pkg::ST_B0: cmd_o.w_raddr = slu_pkg::rhs_addr(i_q);
      slu_pkg::ST_B1: begin
        cmd_o.s_ld = 1'b1;
        k_d = i_p1;
        kend_d = n;
      end
      slu_pkg::ST_B_DIV: cmd_o.w_raddr = slu_pkg::mat_addr(i_q, i_q);
      slu_pkg::ST_B_DW: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_back  = 1'b1;
      end
      slu_pkg::ST_O_RD: cmd_o.w_raddr = slu_pkg::rhs_addr(i_q);
      slu_pkg::ST_O_W:  cmd_o.out_ld_sol = 1'b1;
      slu_pkg::ST_O_WAIT: begin
        if (!status_i.out_busy && (i_q != nm1)) i_d = i_p1;
      end
      slu_pkg::ST_SING: begin
        cmd_o.out_ld_sing = 1'b1;
        parity_d = 1'b0;
      end
      default: ;
    endcase
    // div_back follows the mode while the divider runs and its quotient is written
    if (state_q == slu_pkg::ST_DIV_RUN || state_q == slu_pkg::ST_DIV_WR) begin
      cmd_o.div_back = (mode_q == slu_pkg::MODE_BACK);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= slu_pkg::ST_IDLE;
      mode_q   <= slu_pkg::MODE_LU;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      kend_q   <= '0;
      best_q   <= '0;
      c_q      <= '0;
      parity_q <= 1'b0;
      size_q   <= 2'd3;
      for (int r = 0; r < slu_pkg::MaxOrder; r++) begin
        perm_q[r] <= '0;
      end
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      kend_q   <= kend_d;
      best_q   <= best_d;
      c_q      <= c_d;
      parity_q <= parity_d;
      if (matrix_size_we_i) size_q <= matrix_size_i;
      if (perm_we) perm_q[j_q] <= best_q;
    end
  end

endmodule

>>> hw/rtl/small_lu_linear_solver.sv
// Top level of the small LU linear solver: controller plus datapath.
// Depends on slu_pkg, slu_ctrl, slu_dp (and through it slu_ram, slu_div).
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   config   | matrix_size_we_i       | matrix_size_i
//   input    | in_valid_i/in_ready_o  | operation_i row_i column_i value_i
//   output   | out_valid_o/out_ready_i| element_index_o solution_o singular_o
//            |                        | odd_swaps_o last_o
//
// A solve copies the loaded system into a working store, then runs the
// sequencer with at most one store read per cycle and a bit-serial divider;
// at order 3 it performs six divisions. Input stays not ready from the solve
// until its last result has transferred. Reset clears control state and the
// row scales only; a stalled output holds the sequencer in place.
module small_lu_linear_solver (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             matrix_size_we_i,
  input  logic [1:0]                       matrix_size_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       operation_i,
  input  logic [slu_pkg::IdxW-1:0]         row_i,
  input  logic [slu_pkg::IdxW-1:0]         column_i,
  input  logic signed [slu_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [slu_pkg::IdxW-1:0]         element_index_o,
  output logic signed [slu_pkg::DataW-1:0] solution_o,
  output logic                             singular_o,
  output logic                             odd_swaps_o,
  output logic                             last_o
);

  slu_pkg::cmd_t    cmd;
  slu_pkg::status_t status;

  slu_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .matrix_size_we_i (matrix_size_we_i),
    .matrix_size_i    (matrix_size_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  slu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .status_o        (status),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .element_index_o (element_index_o),
    .solution_o      (solution_o),
    .singular_o      (singular_o),
    .odd_swaps_o     (odd_swaps_o),
    .last_o          (last_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_solve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && operation_i == slu_pkg::OP_SOLVE) |=> !in_ready_o)
    else $error("input ready right after a solve transfer");

  a_singular_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |-> (last_o && !odd_swaps_o && solution_o == '0))
    else $error("singular result malformed");

endmodule

>>> dv/tb.sv
// Testbench for small_lu_linear_solver: directed table then random load/solve
// sequences, checked against an in-bench LU solver model. Depends on slu_pkg.
module tb;

  // operation code with no effect
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] val;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] sol;
    logic        sing;
    logic        odd;
    logic        last;
  } sol_t;

  typedef struct {
    logic [1:0]  cfg;   // 0: no write, else matrix_size
    cmd_item_t   item;
    logic        has_exp;
    sol_t        exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic matrix_size_we_i = 1'b0;
  logic [1:0] matrix_size_i = 2'd3;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = '0;
  logic [1:0] row_i = '0;
  logic [1:0] column_i = '0;
  logic signed [31:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] element_index_o;
  logic signed [31:0] solution_o;
  logic singular_o, odd_swaps_o, last_o;

  always #1 clk_i = ~clk_i;

  small_lu_linear_solver dut (.*);

  // predictor state
  logic [1:0]         order_reg = 2'd3;
  logic signed [31:0] mat_m [9];
  logic signed [31:0] rhs_m [3];
  logic [1:0]         perm_m [3];
  logic [31:0]        scale_m [3];
  logic               parity_m;
  sol_t               sol_q[$];
  bit                 failed = 0;
  bit                 wr_a [9];
  bit                 wr_b [3];

  function automatic logic signed [31:0] sat(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return sat(p / 66'sd65536);
  endfunction

  function automatic logic signed [31:0] qdiv(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [65:0] nm;
    if (b == 0) b = 1;
    nm = 66'(a) * 66'sd65536;
    return sat(nm / 66'(b));
  endfunction

  function automatic logic signed [31:0] qsub(logic signed [31:0] a, logic signed [31:0] b);
    return sat(66'(a) - 66'(b));
  endfunction

  function automatic logic [31:0] mag(logic signed [31:0] a);
    return a[31] ? 32'(-a) : a;
  endfunction

  task automatic predict_solve();
    int n, i, j, k, best, p;
    logic signed [31:0] a [3][3];
    logic signed [31:0] b [3];
    logic signed [31:0] s, t;
    logic [31:0] big, bm, m, ts;
    sol_t r;
    n = (order_reg == 0) ? 1 : order_reg;
    for (i = 0; i < n; i++) for (j = 0; j < n; j++) a[i][j] = mat_m[i*3+j];
    parity_m = 0;
    for (i = 0; i < n; i++) begin
      big = 0;
      for (j = 0; j < n; j++) if (mag(a[i][j]) > big) big = mag(a[i][j]);
      if (big == 0) begin
        r = '{idx: 2'd0, sol: 32'h0, sing: 1'b1, odd: 1'b0, last: 1'b1};
        sol_q.push_back(r);
        return;
      end
      scale_m[i] = big;
    end
    for (j = 0; j < n; j++) begin
      best = j;
      bm = 0;
      for (i = 0; i < j; i++) begin
        s = a[i][j];
        for (k = 0; k < i; k++) s = qsub(s, qmul(a[i][k], a[k][j]));
        a[i][j] = s;
      end
      for (i = j; i < n; i++) begin
        s = a[i][j];
        for (k = 0; k < j; k++) s = qsub(s, qmul(a[i][k], a[k][j]));
        a[i][j] = s;
        m = mag(s);
        if (i == j || 64'(m) * 64'(scale_m[best]) >= 64'(bm) * 64'(scale_m[i])) begin
          best = i;
          bm = m;
        end
      end
      if (best != j) begin
        for (k = 0; k < n; k++) begin
          t = a[best][k]; a[best][k] = a[j][k]; a[j][k] = t;
        end
        ts = scale_m[best]; scale_m[best] = scale_m[j]; scale_m[j] = ts;
        parity_m ^= 1;
      end
      perm_m[j] = 2'(best);
      if (a[j][j] == 0) a[j][j] = 1;
      for (i = j + 1; i < n; i++) a[i][j] = qdiv(a[i][j], a[j][j]);
    end
    for (i = 0; i < n; i++) b[i] = rhs_m[i];
    for (i = 0; i < n; i++) begin
      p = perm_m[i];
      if (p >= n) p = i;
      s = b[p];
      b[p] = b[i];
      for (j = 0; j < i; j++) s = qsub(s, qmul(a[i][j], b[j]));
      b[i] = s;
    end
    for (i = n - 1; i >= 0; i--) begin
      s = b[i];
      for (j = i + 1; j < n; j++) s = qsub(s, qmul(a[i][j], b[j]));
      b[i] = qdiv(s, a[i][i]);
    end
    for (i = 0; i < n; i++) begin
      r = '{idx: 2'(i), sol: b[i], sing: 1'b0, odd: parity_m, last: (i == n - 1)};
      sol_q.push_back(r);
    end
  endtask

  task automatic apply_item(cmd_item_t it);
    if (it.op == slu_pkg::OP_LOAD_A && it.row < 3 && it.col < 3) begin
      mat_m[it.row*3+it.col] = it.val;
      wr_a[it.row*3+it.col] = 1;
    end else if (it.op == slu_pkg::OP_LOAD_B && it.row < 3) begin
      rhs_m[it.row] = it.val;
      wr_b[it.row] = 1;
    end else if (it.op == slu_pkg::OP_SOLVE) begin
      predict_solve();
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // returns at the accepting edge; valid stays up until the next send or idle_input
  task automatic send(cmd_item_t it);
    int g;
    g = gap_len();
    @(negedge clk_i);
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    operation_i <= it.op;
    row_i <= it.row;
    column_i <= it.col;
    value_i <= it.val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(it);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_and_config(logic [1:0] sz);
    idle_input();
    while (sol_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    matrix_size_i <= sz;
    matrix_size_we_i <= 1'b1;
    @(negedge clk_i);
    matrix_size_we_i <= 1'b0;
    order_reg = sz;
  endtask

  // output side: random stalls, compare at the rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 40) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sol_q.size() == 0) begin
        $display("%0t: unexpected result idx=%0d sol=%h", $time, element_index_o, solution_o);
        failed = 1;
      end else begin
        sol_t e;
        e = sol_q.pop_front();
        if (e != {element_index_o, solution_o, singular_o, odd_swaps_o, last_o}) begin
          $display("%0t: mismatch exp idx=%0d sol=%h sing=%b odd=%b last=%b", $time,
                   e.idx, e.sol, e.sing, e.odd, e.last);
          $display("%0t:          got idx=%0d sol=%h sing=%b odd=%b last=%b", $time,
                   element_index_o, solution_o, singular_o, odd_swaps_o, last_o);
          failed = 1;
        end
      end
    end
  end

  function automatic cmd_item_t mk(logic [1:0] op, logic [1:0] r, logic [1:0] c,
                                   logic [31:0] v);
    mk = '{op: op, row: r, col: c, val: v};
  endfunction

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      3: return 32'($urandom_range(0, 3) << 16);
      default: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
    endcase
  endfunction

  row_t dir_tab[$];

  initial begin
    row_t rw;
    int phase;
    for (int i = 0; i < 9; i++) begin mat_m[i] = 0; wr_a[i] = 0; end
    for (int i = 0; i < 3; i++) begin
      rhs_m[i] = 0; wr_b[i] = 0; perm_m[i] = 0; scale_m[i] = 0;
    end
    parity_m = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: order 1 identity, then singular, then extremes, an unused opcode and out-of-range loads
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_LOAD_A, 2'd0, 2'd0, 32'h0001_0000), 1'b0, '0});
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_LOAD_B, 2'd0, 2'd0, 32'h0003_0000), 1'b0, '0});
    dir_tab.push_back('{2'd1, mk(slu_pkg::OP_SOLVE, 2'd0, 2'd0, 32'h0), 1'b1,
                       '{2'd0, 32'h0003_0000, 1'b0, 1'b0, 1'b1}});
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_LOAD_A, 2'd0, 2'd0, 32'h0), 1'b0, '0});
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_SOLVE, 2'd0, 2'd0, 32'h0), 1'b1,
                       '{2'd0, 32'h0, 1'b1, 1'b0, 1'b1}});
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_LOAD_A, 2'd0, 2'd0, 32'h8000_0000), 1'b0, '0});
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_LOAD_B, 2'd0, 2'd0, 32'h7fff_ffff), 1'b0, '0});
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_SOLVE, 2'd0, 2'd0, 32'h0), 1'b0, '0});
    dir_tab.push_back('{2'd0, mk(OpUnused, 2'd0, 2'd0, 32'hffff_ffff), 1'b0, '0});
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_LOAD_A, 2'd3, 2'd3, 32'h1234_5678), 1'b0, '0});
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_LOAD_B, 2'd3, 2'd2, 32'h1234_5678), 1'b0, '0});
    dir_tab.push_back('{2'd0, mk(slu_pkg::OP_SOLVE, 2'd0, 2'd0, 32'h0), 1'b0, '0});
    foreach (dir_tab[t]) begin
      rw = dir_tab[t];
      if (rw.cfg != 0) drain_and_config(rw.cfg);
      if (rw.has_exp) begin
        idle_input();
        while (sol_q.size() != 0) @(negedge clk_i);
        send(rw.item);
        if (sol_q.size() != 1 || sol_q[0] != rw.exp) begin
          $display("%0t: table row %0d predicts %h, table says %h", $time, t,
                   sol_q.size() ? sol_q[0] : '0, rw.exp);
          failed = 1;
        end
      end else begin
        send(rw.item);
      end
    end
    // size 0 acts as 1, then full order with row swaps
    drain_and_config(2'd0);
    send(mk(slu_pkg::OP_SOLVE, 2'd0, 2'd0, 32'h0));
    drain_and_config(2'd3);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send(mk(slu_pkg::OP_LOAD_A, 2'(r), 2'(c), (r == 2 - c) ? 32'h0002_0000 : 32'h0));
      end
      send(mk(slu_pkg::OP_LOAD_B, 2'(r), 2'd0, 32'(32'h0001_0000 * (r + 1))));
    end
    send(mk(slu_pkg::OP_SOLVE, 2'd0, 2'd0, 32'h0));
    send(mk(slu_pkg::OP_LOAD_A, 2'd1, 2'd1, 32'h0002_0000));
    send(mk(slu_pkg::OP_LOAD_A, 2'd0, 2'd2, 32'h0001_0000));
    send(mk(slu_pkg::OP_SOLVE, 2'd0, 2'd0, 32'h0));

    // random: phases with a size each, mostly full reloads then solve
    phase = 0;
    for (int cnt = 0; cnt < 230; ) begin
      int n;
      drain_and_config(phase % 4 == 3 ? 2'd0 : 2'($urandom_range(1, 3)));
      n = (order_reg == 0) ? 1 : order_reg;
      for (int s = 0; s < 4; s++) begin
        for (int r = 0; r < n; r++) begin
          for (int c = 0; c < n; c++) begin
            if (!wr_a[r*3+c] || $urandom_range(0, 3) != 0) begin
              send(mk(slu_pkg::OP_LOAD_A, 2'(r), 2'(c),
                      $urandom_range(0, 9) == 0 ? 32'h0 : rnd_val()));
              cnt++;
            end
          end
          if (!wr_b[r] || $urandom_range(0, 2) != 0) begin
            send(mk(slu_pkg::OP_LOAD_B, 2'(r), 2'($urandom), rnd_val()));
            cnt++;
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          send(mk($urandom_range(0, 1) ? OpUnused : slu_pkg::OP_LOAD_A, 2'd3,
                  2'($urandom), $urandom));
          cnt++;
        end
        send(mk(slu_pkg::OP_SOLVE, 2'($urandom), 2'($urandom), $urandom));
        cnt++;
      end
      phase++;
    end

    idle_input();
    while (sol_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/slu_pkg.sv
hw/rtl/slu_ram.sv
hw/rtl/slu_div.sv
hw/rtl/slu_dp.sv
hw/rtl/slu_ctrl.sv
hw/rtl/small_lu_linear_solver.sv
dv/tb.sv
